/* rtl/ocl_pkg.sv */
// ----------------------------------------------------------------------------
// ocl_pkg: shared types and codes for the ordered counted list
// Request and result payloads, the per-cell entry, the control broadcast to
// the cell row and the status each cell reports back.
// ----------------------------------------------------------------------------
package ocl_pkg;

  localparam int TYPE_W  = 8;
  localparam int COUNT_W = 8;
  localparam int SLOT_W  = 5;
  localparam int USED_W  = 6;

  // request commands
  localparam logic [1:0] CMD_ADD_ENTRY = 2'd0;
  localparam logic [1:0] CMD_ADD_RES   = 2'd1;
  localparam logic [1:0] CMD_DEL_SLOT  = 2'd2;
  localparam logic [1:0] CMD_SUB_RES   = 2'd3;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOHIT = 2'd2;

  // cell operations
  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_INS  = 3'd1;
  localparam logic [2:0] OP_DEL  = 3'd2;
  localparam logic [2:0] OP_INC  = 3'd3;
  localparam logic [2:0] OP_SUB  = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TYPE_W-1:0]  kind_code;
    logic [COUNT_W-1:0] item_count;
    logic               at_head;
    logic [SLOT_W-1:0]  slot_index;
  } ocl_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TYPE_W-1:0]  removed_type;
    logic [COUNT_W-1:0] removed_count;
    logic               removed_valid;
    logic [USED_W-1:0]  entries_used;
  } ocl_out_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [COUNT_W-1:0] amount;
  } entry_t;

  typedef struct packed {
    logic [2:0]         op;
    entry_t             new_entry;
    logic [TYPE_W-1:0]  key;
    logic               check_amt;
    logic [COUNT_W-1:0] sub_amount;
  } cell_ctrl_t;

  typedef struct packed {
    logic   hit;
    logic   zero;
    entry_t rd;
  } cell_stat_t;

endpackage

/* rtl/ocl_cell.sv */
// ----------------------------------------------------------------------------
// ocl_cell: one slot of the ordered list
// Holds one entry, matches it against the broadcast key when selected and
// takes its neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module ocl_cell #(
  parameter int IDX   = 0,
  parameter int SEL_W = 6
) (
  input  logic               clk,
  input  ocl_pkg::cell_ctrl_t ctrl,
  input  logic [SEL_W-1:0]   sel,
  input  ocl_pkg::entry_t    left_in,
  input  ocl_pkg::entry_t    right_in,
  output ocl_pkg::entry_t    entry_out,
  output ocl_pkg::cell_stat_t stat_out
);
  import ocl_pkg::*;

  localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

  entry_t entry_r, entry_nxt;
  logic   here, match;

  assign here  = (sel == MY_IDX);
  assign match = (entry_r.kind == ctrl.key) &&
                 (!ctrl.check_amt || (entry_r.amount >= ctrl.sub_amount));

  assign stat_out.hit  = here && match;
  assign stat_out.zero = here && match && (entry_r.amount == ctrl.sub_amount);
  assign stat_out.rd   = here ? entry_r : '0;
  assign entry_out     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_INS: begin
        if (here) begin
          entry_nxt = ctrl.new_entry;
        end else if (sel < MY_IDX) begin
          entry_nxt = left_in;
        end
      end
      OP_DEL: begin
        if (sel <= MY_IDX) begin
          entry_nxt = right_in;
        end
      end
      OP_INC: begin
        if (here && (entry_r.amount != COUNT_MAX)) begin
          entry_nxt.amount = entry_r.amount + COUNT_W'(1);
        end
      end
      OP_SUB: begin
        if (here) begin
          entry_nxt.amount = entry_r.amount - ctrl.sub_amount;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* rtl/ordered_counted_list_core.sv */
// ----------------------------------------------------------------------------
// ordered_counted_list_core: compact ordered list with type match and counts
// Row of list cells plus a small sequencer that walks a search position down
// the row, applies insert, delete, increment and subtract, and registers one
// result for each request.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | payload
//   --------+------------------------------+----------------------------
//   request | in_valid, in_stall, in_data  | cmd, type, count, head, slot
//   result  | out_valid, out_stall, out_data | status, removed entry, fill
//
// Add entry and remove slot finish in the accept cycle: the result is shown
// the cycle after. Add resource and remove resource walk the search position
// one cell per cycle from the head until a match, or up to the fill count when
// nothing matches, and register the result when the walk ends.
// Reset clears the fill count, sequencer and result valid flag; cell contents
// are undefined until written. A stalled result holds; a new request is taken
// in the cycle the held result drains.
// ----------------------------------------------------------------------------
module ordered_counted_list_core #(
  parameter int LIST_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ocl_pkg::ocl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ocl_pkg::ocl_out_t out_data
);
  import ocl_pkg::*;

  // fill count and search position both need to reach LIST_DEPTH
  localparam int FW    = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (FW > SLOT_W) ? FW : SLOT_W;
  localparam logic [FW-1:0] DEPTH_F = FW'(LIST_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic            state_r, state_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [FW-1:0]   scan_r, scan_nxt;
  ocl_in_t         req_r, req_nxt;
  logic            out_valid_r, out_valid_nxt;
  ocl_out_t        out_r;

  ocl_in_t         cur;
  cell_ctrl_t      ctrl;
  logic [FW-1:0]   sel;
  logic [FW-1:0]   ins_pos;
  logic            accept, out_free, full, any_hit, any_zero;
  logic            res_load;
  ocl_out_t        res;
  entry_t          rd_entry;

  entry_t          cell_entry [LIST_DEPTH];
  cell_stat_t      cell_stat  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] hit_v, zero_v;

  // ---- cell row ------------------------------------------------------------
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_head
      assign left_e = ctrl.new_entry;
    end else begin : g_mid_l
      assign left_e = cell_entry[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[g];
    end else begin : g_mid_r
      assign right_e = cell_entry[g+1];
    end

    ocl_cell #(
      .IDX   (g),
      .SEL_W (FW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel       (sel),
      .left_in   (left_e),
      .right_in  (right_e),
      .entry_out (cell_entry[g]),
      .stat_out  (cell_stat[g])
    );

    assign hit_v[g]  = cell_stat[g].hit;
    assign zero_v[g] = cell_stat[g].zero;
  end

  assign any_hit  = |hit_v;
  assign any_zero = |zero_v;

  // only the selected cell drives its entry, so an OR collects it
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      rd_entry = rd_entry | cell_stat[i].rd;
    end
  end

  // ---- handshake -----------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill_r == DEPTH_F);

  // work on the incoming request in idle, the held one while scanning
  assign cur     = (state_r == S_IDLE) ? in_data : req_r;
  assign ins_pos = cur.at_head ? '0 : fill_r;

  always_comb begin
    ctrl.op               = OP_HOLD;
    ctrl.new_entry.kind   = cur.kind_code;
    ctrl.new_entry.amount = (cur.cmd == CMD_ADD_ENTRY) ? cur.item_count : COUNT_W'(1);
    ctrl.key              = cur.kind_code;
    ctrl.check_amt        = (cur.cmd == CMD_SUB_RES);
    ctrl.sub_amount       = cur.item_count;

    sel       = '0;
    state_nxt = state_r;
    scan_nxt  = scan_r;
    fill_nxt  = fill_r;
    req_nxt   = req_r;
    res_load  = 1'b0;
    res       = '0;
    res.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          case (in_data.cmd)
            CMD_ADD_ENTRY: begin
              res_load = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ctrl.op  = OP_INS;
                sel      = ins_pos;
                fill_nxt = fill_r + FW'(1);
              end
            end
            CMD_DEL_SLOT: begin
              res_load = 1'b1;
              if (CMP_W'(in_data.slot_index) >= CMP_W'(fill_r)) begin
                res.status = ST_NOHIT;
              end else begin
                // slot is below the fill count, so it fits the select width
                sel               = FW'(in_data.slot_index);
                ctrl.op           = OP_DEL;
                fill_nxt          = fill_r - FW'(1);
                res.removed_type  = rd_entry.kind;
                res.removed_count = rd_entry.amount;
                res.removed_valid = 1'b1;
              end
            end
            default: begin
              // resource commands search from the head
              state_nxt = S_SCAN;
              scan_nxt  = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (scan_r == fill_r) begin
            // walked past the last entry: no match
            res_load  = 1'b1;
            state_nxt = S_IDLE;
            if (req_r.cmd == CMD_ADD_RES) begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ctrl.op  = OP_INS;
                sel      = ins_pos;
                fill_nxt = fill_r + FW'(1);
              end
            end else begin
              res.status = ST_NOHIT;
            end
          end else begin
            sel = scan_r;
            if (any_hit) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (req_r.cmd == CMD_ADD_RES) begin
                ctrl.op = OP_INC;
              end else if (any_zero) begin
                // count drops to zero: drop the entry and close the gap
                ctrl.op           = OP_DEL;
                fill_nxt          = fill_r - FW'(1);
                res.removed_type  = req_r.kind_code;
                res.removed_valid = 1'b1;
              end else begin
                ctrl.op = OP_SUB;
              end
            end else begin
              // advance to the next cell
              scan_nxt = scan_r + FW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.entries_used = USED_W'(fill_nxt);
  end

  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: hold a stalled result, load a fresh one
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* dv/tb_ordered_counted_list_core.sv */
// ----------------------------------------------------------------------------
// tb_ordered_counted_list_core: self-checking bench for the ordered list core
// Drives list commands through the request channel and predicts each result
// from a shadow copy of the list kept in the bench. Short directed cases come
// first, then random command mixes that grow the list to full and shrink it
// back to empty, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_ordered_counted_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ocl_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int LIST_SLOTS = 32;
  // settle margin: the slowest command walks the whole row
  localparam int SETTLE_CYCLES = LIST_SLOTS + 8;
  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ocl_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ocl_out_t out_data;

  // shadow of the list contents and fill count
  logic [TYPE_W-1:0]  slot_kind   [LIST_SLOTS];
  logic [COUNT_W-1:0] slot_amount [LIST_SLOTS];
  int                 used_slots;

  ocl_out_t list_results_due[$];
  int       fail_count;
  bit       idle_enabled;

  ordered_counted_list_core #(
    .LIST_DEPTH(LIST_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow list
  // --------------------------------------------------------------------------

  // Place a new entry at the head (shifting the rest down) or at the tail.
  function automatic logic [1:0] list_insert(input logic [TYPE_W-1:0] kind,
                                             input logic [COUNT_W-1:0] amount,
                                             input logic head);
    if (used_slots >= LIST_SLOTS) return ST_FULL;
    if (head) begin
      for (int i = used_slots; i > 0; i--) begin
        slot_kind[i]   = slot_kind[i-1];
        slot_amount[i] = slot_amount[i-1];
      end
      slot_kind[0]   = kind;
      slot_amount[0] = amount;
    end else begin
      slot_kind[used_slots]   = kind;
      slot_amount[used_slots] = amount;
    end
    used_slots++;
    return ST_OK;
  endfunction

  // Close the gap left by the entry at pos.
  function automatic void list_remove(input int pos);
    for (int i = pos; i + 1 < used_slots; i++) begin
      slot_kind[i]   = slot_kind[i+1];
      slot_amount[i] = slot_amount[i+1];
    end
    used_slots--;
  endfunction

  // Apply one accepted request to the shadow list and return its result.
  function automatic ocl_out_t apply_list_command(input ocl_in_t req);
    ocl_out_t res;
    int       hit;
    res = '0;
    hit = -1;
    case (req.cmd)
      CMD_ADD_ENTRY: begin
        res.status = list_insert(req.kind_code, req.item_count, req.at_head);
      end
      CMD_ADD_RES: begin
        for (int i = 0; i < used_slots; i++)
          if (hit < 0 && slot_kind[i] == req.kind_code) hit = i;
        if (hit >= 0) begin
          // saturate at the top of the count range
          if (slot_amount[hit] != COUNT_MAX) slot_amount[hit]++;
        end else begin
          res.status = list_insert(req.kind_code, COUNT_W'(1), req.at_head);
        end
      end
      CMD_DEL_SLOT: begin
        if (int'(req.slot_index) >= used_slots) begin
          res.status = ST_NOHIT;
        end else begin
          res.removed_type  = slot_kind[req.slot_index];
          res.removed_count = slot_amount[req.slot_index];
          res.removed_valid = 1'b1;
          list_remove(int'(req.slot_index));
        end
      end
      default: begin
        // first entry of the type that holds enough
        for (int i = 0; i < used_slots; i++)
          if (hit < 0 && slot_kind[i] == req.kind_code && slot_amount[i] >= req.item_count)
            hit = i;
        if (hit < 0) begin
          res.status = ST_NOHIT;
        end else begin
          slot_amount[hit] = slot_amount[hit] - req.item_count;
          if (slot_amount[hit] == '0) begin
            res.removed_type  = slot_kind[hit];
            res.removed_valid = 1'b1;
            list_remove(hit);
          end
        end
      end
    endcase
    res.entries_used = USED_W'(used_slots);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (got_v !== exp_v)
      note_failure($sformatf("%s expected %0h actual %0h", name, exp_v, got_v));
  endtask

  task automatic check_list_result(input ocl_out_t got);
    ocl_out_t exp;
    if (list_results_due.size() == 0) begin
      note_failure($sformatf("result %h with nothing outstanding", got));
      return;
    end
    exp = list_results_due.pop_front();
    compare_field("status", 8'(exp.status), 8'(got.status));
    compare_field("removed_type", exp.removed_type, got.removed_type);
    compare_field("removed_count", exp.removed_count, got.removed_count);
    compare_field("removed_valid", 8'(exp.removed_valid), 8'(got.removed_valid));
    compare_field("entries_used", 8'(exp.entries_used), 8'(got.entries_used));
  endtask

  // Sample the result channel at the edge, before anything updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_list_result(out_data);
  end

  // Receiver backpressure: random stall unless idling is switched off.
  always @(posedge clk) begin
    out_stall <= idle_enabled && ($urandom_range(99) < 11);
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Hold valid until the request is taken, then predict its result. Valid is
  // left high on return so back-to-back requests never drop it mid-step.
  task automatic send_request(input ocl_in_t req);
    while (idle_enabled && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    list_results_due.push_back(apply_list_command(req));
  endtask

  // Drop valid and hold until every predicted result has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (list_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic ocl_in_t make_request(input logic [1:0] cmd,
                                           input logic [TYPE_W-1:0] kind,
                                           input logic [COUNT_W-1:0] count,
                                           input logic head,
                                           input logic [SLOT_W-1:0] slot);
    ocl_in_t req;
    req.cmd        = cmd;
    req.kind_code  = kind;
    req.item_count = count;
    req.at_head    = head;
    req.slot_index = slot;
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty-list errors, saturation, zero counts, first-match rules, bad slots.
  task automatic test_directed_cases();
    // empty list: every removal misses
    send_request(make_request(CMD_DEL_SLOT, 8'h00, 8'h00, 1'b0, 5'd0));
    send_request(make_request(CMD_DEL_SLOT, 8'hFF, 8'hFF, 1'b1, 5'd31));
    send_request(make_request(CMD_SUB_RES, 8'h00, 8'h00, 1'b0, 5'd0));
    // add resource with no match creates a count-one entry
    send_request(make_request(CMD_ADD_RES, 8'h5A, 8'h00, 1'b0, 5'd0));
    send_request(make_request(CMD_ADD_ENTRY, 8'hFF, 8'hFF, 1'b1, 5'd0));
    send_request(make_request(CMD_ADD_ENTRY, 8'h00, 8'h00, 1'b0, 5'd31));
    // increment at full count holds at the top
    send_request(make_request(CMD_ADD_RES, 8'hFF, 8'h00, 1'b0, 5'd0));
    send_request(make_request(CMD_ADD_RES, 8'h5A, 8'hFF, 1'b1, 5'd31));
    send_request(make_request(CMD_ADD_RES, 8'hA5, 8'h00, 1'b1, 5'd0));
    // zero from a zero-count entry deletes it
    send_request(make_request(CMD_SUB_RES, 8'h00, 8'h00, 1'b0, 5'd0));
    // too much to take, then a partial take, then an emptying take
    send_request(make_request(CMD_SUB_RES, 8'h5A, 8'h03, 1'b0, 5'd0));
    send_request(make_request(CMD_SUB_RES, 8'h5A, 8'h01, 1'b0, 5'd0));
    send_request(make_request(CMD_SUB_RES, 8'hFF, 8'hFF, 1'b1, 5'd0));
    // second entry of a type qualifies when the first holds too little
    send_request(make_request(CMD_ADD_ENTRY, 8'h5A, 8'h07, 1'b0, 5'd0));
    send_request(make_request(CMD_SUB_RES, 8'h5A, 8'h05, 1'b0, 5'd0));
    send_request(make_request(CMD_SUB_RES, 8'h5A, 8'h00, 1'b0, 5'd0));
    // slot at the fill count misses, inside it removes
    send_request(make_request(CMD_DEL_SLOT, 8'h00, 8'h00, 1'b0, 5'd3));
    send_request(make_request(CMD_DEL_SLOT, 8'h00, 8'h00, 1'b0, 5'd2));
    send_request(make_request(CMD_DEL_SLOT, 8'h00, 8'h00, 1'b1, 5'd0));
    send_request(make_request(CMD_DEL_SLOT, 8'h00, 8'h00, 1'b0, 5'd0));
    send_request(make_request(CMD_SUB_RES, 8'h5A, 8'h01, 1'b0, 5'd0));
  endtask

  // Random commands biased toward hits. The list swings between growing and
  // shrinking so it reaches both full and empty; about one request in ten is
  // fully random noise.
  task automatic test_random_mix(input int n_items);
    ocl_in_t            req;
    int                 r;
    int                 pick;
    int                 add_pct;
    logic [COUNT_W-1:0] held;
    bit                 grow;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (used_slots == 0) grow = 1'b1;
      else if (used_slots == LIST_SLOTS && $urandom_range(3) == 0) grow = 1'b0;
      else if ($urandom_range(63) == 0) grow = !grow;

      req = make_request(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                         5'($urandom));
      pick    = (used_slots > 0) ? $urandom_range(used_slots - 1) : 0;
      held    = slot_amount[pick];
      add_pct = grow ? 70 : 20;
      r       = $urandom_range(99);

      if ($urandom_range(99) < 10) begin
        // noise: leave every field random
      end else if (r < add_pct / 2) begin
        req.cmd = CMD_ADD_ENTRY;
        // small type pool so duplicates exercise first-match priority
        if ($urandom_range(1) == 0) req.kind_code = 8'($urandom_range(7));
        if ($urandom_range(3) == 0) req.item_count = 8'($urandom_range(250, 255));
      end else if (r < add_pct) begin
        req.cmd = CMD_ADD_RES;
        if (used_slots > 0 && $urandom_range(9) < 7) req.kind_code = slot_kind[pick];
      end else if (r < add_pct + (100 - add_pct) / 2) begin
        req.cmd = CMD_DEL_SLOT;
        if (used_slots > 0 && $urandom_range(9) != 0) req.slot_index = 5'(pick);
      end else begin
        req.cmd = CMD_SUB_RES;
        if (used_slots > 0 && $urandom_range(9) != 0) begin
          req.kind_code = slot_kind[pick];
          case ($urandom_range(4))
            0, 1:    req.item_count = held;
            2, 3:    req.item_count = 8'($urandom_range(held));
            default: req.item_count = held + 8'd1;
          endcase
        end
      end

      // pause now and then until the core has answered everything
      if (k % 300 == 299) wait_for_drain();
      send_request(req);
    end
  endtask

  // Both channels without idle or stall: back-to-back requests.
  task automatic test_back_to_back(input int n_items);
    idle_enabled = 1'b0;
    test_random_mix(n_items);
    idle_enabled = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    idle_enabled = 1'b1;
    fail_count   = 0;
    used_slots   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_mix(700);
    test_back_to_back(300);
    test_random_mix(700);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && list_results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/ocl_pkg.sv
rtl/ocl_cell.sv
rtl/ordered_counted_list_core.sv
dv/tb_ordered_counted_list_core.sv
